// ----- hw/rtl/imt_pkg.sv -----
// ----------------------------------------------------------------------------
// imt_pkg
// Shared types, codes and helpers for the IRC message tokenizer.
// ----------------------------------------------------------------------------
package imt_pkg;

  // Parser phase within one line
  typedef enum logic [2:0] {
    PH_FIRST      = 3'd0,
    PH_TAGS       = 3'd1,
    PH_AFTER_TAGS = 3'd2,
    PH_PREFIX     = 3'd3,
    PH_CMD_WAIT   = 3'd4,
    PH_CMD        = 3'd5,
    PH_PARAMS     = 3'd6,
    PH_TRAIL      = 3'd7
  } phase_t;

  // Element kind carried by each result item
  typedef enum logic [2:0] {
    KIND_TAG     = 3'd0,
    KIND_PREFIX  = 3'd1,
    KIND_CMD     = 3'd2,
    KIND_MIDDLE  = 3'd3,
    KIND_TRAIL   = 3'd4,
    KIND_STATUS  = 3'd5
  } kind_t;

  // Final line status
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY_CMD = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic [2:0] REG_MAX_TAG    = 3'd0;
  localparam logic [2:0] REG_MAX_LINE   = 3'd1;
  localparam logic [2:0] REG_MAX_BODY   = 3'd2;
  localparam logic [2:0] REG_MAX_MIDDLE = 3'd3;

  // Register reset values
  localparam logic [15:0] DEF_MAX_TAG    = 16'd4096;
  localparam logic [15:0] DEF_MAX_LINE   = 16'd4608;
  localparam logic [15:0] DEF_MAX_BODY   = 16'd512;
  localparam logic [7:0]  DEF_MAX_MIDDLE = 8'd15;

  // Special characters
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Line state other than the length counters
  typedef struct packed {
    phase_t     phase;
    logic       inside_token;
    logic       space_pending;
    logic       error_seen;
    logic [7:0] tag_index;
    logic [7:0] param_count;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    phase:         PH_FIRST,
    inside_token:  1'b0,
    space_pending: 1'b0,
    error_seen:    1'b0,
    tag_index:     8'd0,
    param_count:   8'd0
  };

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       carries_byte;
    kind_t      kind;
    logic [7:0] element_index;
    logic       ends_element;
    status_t    status;
    logic       last;
  } res_t;

  // Saturating increment of an 8-bit index
  function automatic logic [7:0] idx_sat(logic [7:0] v);
    idx_sat = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Build a plain (non-status) result
  function automatic res_t mk_res(logic [7:0] b, logic c, kind_t k, logic [7:0] i, logic e);
    res_t r;
    r.out_byte      = b;
    r.carries_byte  = c;
    r.kind          = k;
    r.element_index = i;
    r.ends_element  = e;
    r.status        = ST_OK;
    r.last          = 1'b0;
    mk_res = r;
  endfunction

endpackage

// ----- hw/rtl/irc_message_tokenizer.sv -----
// An accepted byte's result items are written into the result queue at the accepting edge.
// Throughput: one byte per cycle while results drain; a byte that makes two or three
// items (marker or collapsed space plus content, plus the status) keeps the output busy with
// each of them, and the four-entry result queue takes a byte whenever three entries are free.
// Reset: clears the line state and the queue and restores the register defaults at once.
// ----------------------------------------------------------------------------
// irc_message_tokenizer
// Streaming tokenizer for one IRC line with tags: classifies each byte into
// tag, prefix, command and parameter items and closes with a status item.
// ----------------------------------------------------------------------------
module irc_message_tokenizer #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_line
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [15:8] element_index,
                                 // [16] ends_element, [18:17] status, rest zero
  output logic [3:0]  m_tuser,   // [0] carries_byte, [3:1] kind
  output logic        m_tlast,   // last
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0]             max_tag_size;
  logic [15:0]             max_line_bytes;
  logic [15:0]             max_body_bytes;
  logic [7:0]              max_middle_params;

  imt_pkg::line_state_t    line_st;
  imt_pkg::line_state_t    line_st_next;
  logic [LENGTH_WIDTH-1:0] line_len;
  logic [LENGTH_WIDTH-1:0] line_len_next;
  logic [LENGTH_WIDTH-1:0] tag_len;
  logic [LENGTH_WIDTH-1:0] tag_len_next;

  imt_pkg::res_t           step_res [3];
  logic [1:0]              step_cnt;
  logic                    accept;
  logic                    room;
  imt_pkg::res_t           head;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = room;
  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_tag_size      <= imt_pkg::DEF_MAX_TAG;
      max_line_bytes    <= imt_pkg::DEF_MAX_LINE;
      max_body_bytes    <= imt_pkg::DEF_MAX_BODY;
      max_middle_params <= imt_pkg::DEF_MAX_MIDDLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imt_pkg::REG_MAX_TAG:    max_tag_size      <= cfg_data;
        imt_pkg::REG_MAX_LINE:   max_line_bytes    <= cfg_data;
        imt_pkg::REG_MAX_BODY:   max_body_bytes    <= cfg_data;
        imt_pkg::REG_MAX_MIDDLE: max_middle_params <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Per-byte decode
  imt_step #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_step (
    .cur               (line_st),
    .line_len          (line_len),
    .tag_len           (tag_len),
    .data_byte         (s_tdata),
    .end_of_line       (s_tlast),
    .max_tag_size      (max_tag_size),
    .max_line_bytes    (max_line_bytes),
    .max_body_bytes    (max_body_bytes),
    .max_middle_params (max_middle_params),
    .nxt               (line_st_next),
    .line_len_next     (line_len_next),
    .tag_len_next      (tag_len_next),
    .res               (step_res),
    .res_cnt           (step_cnt)
  );

  // Advance line state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      line_st  <= imt_pkg::LINE_CLEAR;
      line_len <= '0;
      tag_len  <= '0;
    end else if (accept) begin
      line_st  <= line_st_next;
      line_len <= line_len_next;
      tag_len  <= tag_len_next;
    end
  end

  // Queue result items
  imt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (accept ? step_cnt : 2'd0),
    .push_res  (step_res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (head)
  );

  assign m_tdata = {5'd0, head.status, head.ends_element, head.element_index, head.out_byte};
  assign m_tuser = {head.kind, head.carries_byte};
  assign m_tlast = head.last;

`ifndef SYNTHESIS
  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> line_st.phase == imt_pkg::PH_FIRST && !line_st.error_seen &&
                          line_len == '0)
    else $error("line state not cleared after final byte");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[3:1] == imt_pkg::KIND_STATUS && !m_tuser[0])
    else $error("final item is not a status item");

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:1] == imt_pkg::KIND_STATUS |-> m_tlast)
    else $error("status item without last");

  a_eol_makes_status: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |-> step_cnt != 2'd0 && step_res[step_cnt - 2'd1].last)
    else $error("final byte gave no status item");

  a_no_content_in_error: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tlast && line_st.error_seen |-> step_cnt == 2'd0)
    else $error("items produced after middle parameter overflow");
`endif

endmodule

// ----- hw/rtl/imt_step.sv -----
// ----------------------------------------------------------------------------
// imt_step
// Per-byte tokenizer logic: next line state and up to three result items.
// ----------------------------------------------------------------------------
module imt_step #(
  parameter int LENGTH_WIDTH = 16
) (
  input  imt_pkg::line_state_t    cur,
  input  logic [LENGTH_WIDTH-1:0] line_len,
  input  logic [LENGTH_WIDTH-1:0] tag_len,
  input  logic [7:0]              data_byte,
  input  logic                    end_of_line,
  input  logic [15:0]             max_tag_size,
  input  logic [15:0]             max_line_bytes,
  input  logic [15:0]             max_body_bytes,
  input  logic [7:0]              max_middle_params,
  output imt_pkg::line_state_t    nxt,
  output logic [LENGTH_WIDTH-1:0] line_len_next,
  output logic [LENGTH_WIDTH-1:0] tag_len_next,
  output imt_pkg::res_t           res [3],
  output logic [1:0]              res_cnt
);

  localparam int CW = (LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16;
  localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

  logic              sp;
  logic              do_close;
  imt_pkg::kind_t    close_kind;
  logic [7:0]        close_idx;
  logic [CW-1:0]     ll_w;
  logic [CW-1:0]     tl_w;
  logic [CW-1:0]     body_w;
  logic              too_long;
  imt_pkg::status_t  st;
  imt_pkg::res_t     st_res;

  assign sp = (data_byte == imt_pkg::CH_SPACE);

  always_comb begin
    nxt           = cur;
    line_len_next = (line_len == LEN_MAX) ? line_len : line_len + LENGTH_WIDTH'(1);
    tag_len_next  = tag_len;
    res_cnt       = 2'd0;
    res[0]        = '0;
    res[1]        = '0;
    res[2]        = '0;
    do_close      = 1'b0;
    close_kind    = imt_pkg::KIND_TAG;
    close_idx     = 8'd0;
    ll_w          = '0;
    tl_w          = '0;
    body_w        = '0;
    too_long      = 1'b0;
    st            = imt_pkg::ST_OK;
    st_res        = '0;

    // Classify the byte against the current phase
    if (!cur.error_seen) begin
      case (cur.phase)
        imt_pkg::PH_FIRST, imt_pkg::PH_AFTER_TAGS, imt_pkg::PH_CMD_WAIT: begin
          if (!sp) begin
            if (cur.phase == imt_pkg::PH_FIRST && data_byte == imt_pkg::CH_AT) begin
              nxt.phase        = imt_pkg::PH_TAGS;
              tag_len_next     = LENGTH_WIDTH'(1);
              nxt.inside_token = 1'b0;
            end else if (cur.phase != imt_pkg::PH_CMD_WAIT &&
                         data_byte == imt_pkg::CH_COLON) begin
              nxt.phase = imt_pkg::PH_PREFIX;
            end else begin
              nxt.phase    = imt_pkg::PH_CMD;
              res[res_cnt] = imt_pkg::mk_res(data_byte, 1'b1, imt_pkg::KIND_CMD, 8'd0, 1'b0);
              res_cnt      = res_cnt + 2'd1;
            end
          end
        end
        imt_pkg::PH_TAGS: begin
          if (sp) begin
            if (cur.inside_token) begin
              res[res_cnt]  = imt_pkg::mk_res(8'd0, 1'b0, imt_pkg::KIND_TAG,
                                              cur.tag_index, 1'b1);
              res_cnt       = res_cnt + 2'd1;
              nxt.tag_index = imt_pkg::idx_sat(cur.tag_index);
            end
            nxt.inside_token = 1'b0;
            nxt.phase        = imt_pkg::PH_AFTER_TAGS;
          end else if (data_byte == imt_pkg::CH_SEMI) begin
            tag_len_next     = (tag_len == LEN_MAX) ? tag_len : tag_len + LENGTH_WIDTH'(1);
            res[res_cnt]     = imt_pkg::mk_res(8'd0, 1'b0, imt_pkg::KIND_TAG,
                                               cur.tag_index, 1'b1);
            res_cnt          = res_cnt + 2'd1;
            nxt.tag_index    = imt_pkg::idx_sat(cur.tag_index);
            nxt.inside_token = 1'b0;
          end else begin
            tag_len_next     = (tag_len == LEN_MAX) ? tag_len : tag_len + LENGTH_WIDTH'(1);
            res[res_cnt]     = imt_pkg::mk_res(data_byte, 1'b1, imt_pkg::KIND_TAG,
                                               cur.tag_index, 1'b0);
            res_cnt          = res_cnt + 2'd1;
            nxt.inside_token = 1'b1;
          end
        end
        imt_pkg::PH_PREFIX: begin
          if (sp) begin
            res[res_cnt] = imt_pkg::mk_res(8'd0, 1'b0, imt_pkg::KIND_PREFIX, 8'd0, 1'b1);
            res_cnt      = res_cnt + 2'd1;
            nxt.phase    = imt_pkg::PH_CMD_WAIT;
          end else begin
            res[res_cnt] = imt_pkg::mk_res(data_byte, 1'b1, imt_pkg::KIND_PREFIX, 8'd0, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
        end
        imt_pkg::PH_CMD: begin
          if (sp) begin
            res[res_cnt]     = imt_pkg::mk_res(8'd0, 1'b0, imt_pkg::KIND_CMD, 8'd0, 1'b1);
            res_cnt          = res_cnt + 2'd1;
            nxt.phase        = imt_pkg::PH_PARAMS;
            nxt.inside_token = 1'b0;
          end else begin
            res[res_cnt] = imt_pkg::mk_res(data_byte, 1'b1, imt_pkg::KIND_CMD, 8'd0, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
        end
        imt_pkg::PH_PARAMS: begin
          if (cur.inside_token) begin
            if (sp) begin
              res[res_cnt] = imt_pkg::mk_res(8'd0, 1'b0, imt_pkg::KIND_MIDDLE,
                                             cur.param_count, 1'b1);
              res_cnt      = res_cnt + 2'd1;
              // count the closed middle parameter
              if (cur.param_count >= max_middle_params) begin
                nxt.error_seen = 1'b1;
              end else begin
                nxt.param_count = imt_pkg::idx_sat(cur.param_count);
              end
              nxt.inside_token = 1'b0;
            end else begin
              res[res_cnt] = imt_pkg::mk_res(data_byte, 1'b1, imt_pkg::KIND_MIDDLE,
                                             cur.param_count, 1'b0);
              res_cnt      = res_cnt + 2'd1;
            end
          end else if (!sp) begin
            if (data_byte == imt_pkg::CH_COLON) begin
              nxt.phase         = imt_pkg::PH_TRAIL;
              nxt.space_pending = 1'b0;
            end else begin
              nxt.inside_token = 1'b1;
              res[res_cnt]     = imt_pkg::mk_res(data_byte, 1'b1, imt_pkg::KIND_MIDDLE,
                                                 cur.param_count, 1'b0);
              res_cnt          = res_cnt + 2'd1;
            end
          end
        end
        default: begin
          // trailing parameter: collapse space runs to one space
          if (sp) begin
            nxt.space_pending = 1'b1;
          end else begin
            if (cur.space_pending) begin
              res[res_cnt] = imt_pkg::mk_res(imt_pkg::CH_SPACE, 1'b1, imt_pkg::KIND_TRAIL,
                                             cur.param_count, 1'b0);
              res_cnt      = res_cnt + 2'd1;
            end
            nxt.space_pending = 1'b0;
            res[res_cnt] = imt_pkg::mk_res(data_byte, 1'b1, imt_pkg::KIND_TRAIL,
                                           cur.param_count, 1'b0);
            res_cnt      = res_cnt + 2'd1;
          end
        end
      endcase
    end

    if (end_of_line) begin
      // Pick the element still open at the final byte
      if (!nxt.error_seen) begin
        if (nxt.phase == imt_pkg::PH_TAGS && nxt.inside_token) begin
          do_close   = 1'b1;
          close_kind = imt_pkg::KIND_TAG;
          close_idx  = nxt.tag_index;
        end else if (nxt.phase == imt_pkg::PH_PREFIX) begin
          do_close   = 1'b1;
          close_kind = imt_pkg::KIND_PREFIX;
        end else if (nxt.phase == imt_pkg::PH_CMD) begin
          do_close   = 1'b1;
          close_kind = imt_pkg::KIND_CMD;
        end else if (nxt.phase == imt_pkg::PH_PARAMS && nxt.inside_token) begin
          do_close   = 1'b1;
          close_kind = imt_pkg::KIND_MIDDLE;
          close_idx  = nxt.param_count;
        end else if (nxt.phase == imt_pkg::PH_TRAIL) begin
          do_close   = 1'b1;
          close_kind = imt_pkg::KIND_TRAIL;
          close_idx  = nxt.param_count;
        end
      end

      // Close on this byte's own content result, else add a marker
      if (do_close) begin
        if (res_cnt != 2'd0 && res[res_cnt - 2'd1].carries_byte &&
            res[res_cnt - 2'd1].kind == close_kind) begin
          res[res_cnt - 2'd1].ends_element = 1'b1;
        end else begin
          res[res_cnt] = imt_pkg::mk_res(8'd0, 1'b0, close_kind, close_idx, 1'b1);
          res_cnt      = res_cnt + 2'd1;
        end
        if (close_kind == imt_pkg::KIND_MIDDLE) begin
          if (nxt.param_count >= max_middle_params) begin
            nxt.error_seen = 1'b1;
          end else begin
            nxt.param_count = imt_pkg::idx_sat(nxt.param_count);
          end
        end
      end

      // Length checks on the saturated counters
      ll_w     = CW'(line_len_next);
      tl_w     = CW'(tag_len_next);
      body_w   = (ll_w >= tl_w) ? ll_w - tl_w : '0;
      too_long = (ll_w > CW'(max_line_bytes));
      if (tl_w != '0) begin
        if (tl_w > CW'(max_tag_size) || body_w > CW'(max_body_bytes)) begin
          too_long = 1'b1;
        end
      end

      // Status priority
      if (nxt.phase == imt_pkg::PH_FIRST) begin
        st = imt_pkg::ST_EMPTY_CMD;
      end else if (too_long) begin
        st = imt_pkg::ST_TOO_LONG;
      end else if (nxt.phase < imt_pkg::PH_CMD) begin
        st = imt_pkg::ST_EMPTY_CMD;
      end else if (nxt.error_seen) begin
        st = imt_pkg::ST_TOO_LONG;
      end else begin
        st = imt_pkg::ST_OK;
      end

      st_res        = imt_pkg::mk_res(8'd0, 1'b0, imt_pkg::KIND_STATUS, 8'd0, 1'b0);
      st_res.status = st;
      st_res.last   = 1'b1;
      res[res_cnt]  = st_res;
      res_cnt       = res_cnt + 2'd1;

      // Return the line state to its start
      nxt           = imt_pkg::LINE_CLEAR;
      line_len_next = '0;
      tag_len_next  = '0;
    end
  end

endmodule

// ----- hw/rtl/imt_fifo.sv -----
// ----------------------------------------------------------------------------
// imt_fifo
// Four-entry result queue: takes up to three items a cycle, gives one while out_ready is high.
// ----------------------------------------------------------------------------
module imt_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_cnt,
  input  imt_pkg::res_t push_res [3],
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output imt_pkg::res_t out_res
);

  imt_pkg::res_t mem [4];
  logic [1:0]    wr_ptr;
  logic [1:0]    rd_ptr;
  logic [2:0]    fill;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill != 3'd0);
  assign out_res   = mem[rd_ptr];
  // room for the worst case of three items from one byte
  assign room      = (fill <= 3'd1);

  // Store pushed items in order
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_cnt) begin
        mem[wr_ptr + 2'(k)] <= push_res[k];
      end
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      rd_ptr <= rd_ptr + 2'(pop);
      fill   <= fill + 3'(push_cnt) - 3'(pop);
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IRC message tokenizer. Lines of bytes go in on
// the slave stream and a line-level tokenizer model predicts every result
// item. Each item on the master stream is compared field by field with the
// oldest prediction. The run walks through several limit settings and uses
// random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index outside the map; writes to it must be ignored
  localparam logic [2:0] REG_SPARE = 3'd6;

  // Predicts the result items of each line and checks the ones that arrive
  class irc_token_checker;
    logic [15:0]      lim_tag, lim_line, lim_body;
    logic [7:0]       lim_mid;
    imt_pkg::phase_t  ph;
    bit               in_tok, sp_pend, too_many;
    bit [15:0]        line_len, tag_len;
    bit [7:0]         tag_idx, n_mid;
    imt_pkg::res_t    line_tokens[$];
    imt_pkg::res_t    expected_tokens[$];
    int               fails;

    function new();
      lim_tag  = imt_pkg::DEF_MAX_TAG;
      lim_line = imt_pkg::DEF_MAX_LINE;
      lim_body = imt_pkg::DEF_MAX_BODY;
      lim_mid  = imt_pkg::DEF_MAX_MIDDLE;
      fails    = 0;
      clear_line();
    endfunction

    function void clear_line();
      ph       = imt_pkg::PH_FIRST;
      in_tok   = 1'b0;
      sp_pend  = 1'b0;
      too_many = 1'b0;
      line_len = '0;
      tag_len  = '0;
      tag_idx  = '0;
      n_mid    = '0;
    endfunction

    function void write_limit(logic [2:0] idx, logic [15:0] val);
      case (idx)
        imt_pkg::REG_MAX_TAG:    lim_tag  = val;
        imt_pkg::REG_MAX_LINE:   lim_line = val;
        imt_pkg::REG_MAX_BODY:   lim_body = val;
        imt_pkg::REG_MAX_MIDDLE: lim_mid  = val[7:0];
        default: ;
      endcase
    endfunction

    function bit [15:0] len_inc(bit [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit [7:0] idx_inc(bit [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function void emit(bit [7:0] b, bit c, imt_pkg::kind_t k, bit [7:0] i, bit e);
      imt_pkg::res_t r;
      r.out_byte      = b;
      r.carries_byte  = c;
      r.kind          = k;
      r.element_index = i;
      r.ends_element  = e;
      r.status        = imt_pkg::ST_OK;
      r.last          = 1'b0;
      line_tokens.insert(line_tokens.size(), r);
    endfunction

    // Close an element at end of line: flag this byte's own item, else add a marker
    function void close_elem(imt_pkg::kind_t k, bit [7:0] i);
      int n;
      n = line_tokens.size();
      if (n > 0 && line_tokens[n-1].carries_byte && line_tokens[n-1].kind == k)
        line_tokens[n-1].ends_element = 1'b1;
      else
        emit(8'h00, 1'b0, k, i, 1'b1);
    endfunction

    function void count_middle();
      if (n_mid >= lim_mid)
        too_many = 1'b1;
      else
        n_mid = idx_inc(n_mid);
    endfunction

    function void note_byte(bit [7:0] b, bit eol);
      bit               sp;
      bit               too_long;
      bit [15:0]        body;
      imt_pkg::status_t st;
      line_tokens.delete();
      sp = (b == imt_pkg::CH_SPACE);
      line_len = len_inc(line_len);

      // Classify the byte by phase; nothing more is reported once over the parameter limit
      if (!too_many) begin
        case (ph)
          imt_pkg::PH_FIRST, imt_pkg::PH_AFTER_TAGS, imt_pkg::PH_CMD_WAIT: begin
            if (!sp) begin
              if (ph == imt_pkg::PH_FIRST && b == imt_pkg::CH_AT) begin
                ph      = imt_pkg::PH_TAGS;
                tag_len = 16'd1;
                in_tok  = 1'b0;
              end else if (ph != imt_pkg::PH_CMD_WAIT && b == imt_pkg::CH_COLON) begin
                ph = imt_pkg::PH_PREFIX;
              end else begin
                ph = imt_pkg::PH_CMD;
                emit(b, 1'b1, imt_pkg::KIND_CMD, 8'd0, 1'b0);
              end
            end
          end
          imt_pkg::PH_TAGS: begin
            if (sp) begin
              if (in_tok) begin
                emit(8'h00, 1'b0, imt_pkg::KIND_TAG, tag_idx, 1'b1);
                tag_idx = idx_inc(tag_idx);
              end
              in_tok = 1'b0;
              ph     = imt_pkg::PH_AFTER_TAGS;
            end else if (b == imt_pkg::CH_SEMI) begin
              tag_len = len_inc(tag_len);
              emit(8'h00, 1'b0, imt_pkg::KIND_TAG, tag_idx, 1'b1);
              tag_idx = idx_inc(tag_idx);
              in_tok  = 1'b0;
            end else begin
              tag_len = len_inc(tag_len);
              emit(b, 1'b1, imt_pkg::KIND_TAG, tag_idx, 1'b0);
              in_tok = 1'b1;
            end
          end
          imt_pkg::PH_PREFIX: begin
            if (sp) begin
              emit(8'h00, 1'b0, imt_pkg::KIND_PREFIX, 8'd0, 1'b1);
              ph = imt_pkg::PH_CMD_WAIT;
            end else begin
              emit(b, 1'b1, imt_pkg::KIND_PREFIX, 8'd0, 1'b0);
            end
          end
          imt_pkg::PH_CMD: begin
            if (sp) begin
              emit(8'h00, 1'b0, imt_pkg::KIND_CMD, 8'd0, 1'b1);
              ph     = imt_pkg::PH_PARAMS;
              in_tok = 1'b0;
            end else begin
              emit(b, 1'b1, imt_pkg::KIND_CMD, 8'd0, 1'b0);
            end
          end
          imt_pkg::PH_PARAMS: begin
            if (in_tok) begin
              if (sp) begin
                emit(8'h00, 1'b0, imt_pkg::KIND_MIDDLE, n_mid, 1'b1);
                count_middle();
                in_tok = 1'b0;
              end else begin
                emit(b, 1'b1, imt_pkg::KIND_MIDDLE, n_mid, 1'b0);
              end
            end else if (!sp) begin
              if (b == imt_pkg::CH_COLON) begin
                ph      = imt_pkg::PH_TRAIL;
                sp_pend = 1'b0;
              end else begin
                in_tok = 1'b1;
                emit(b, 1'b1, imt_pkg::KIND_MIDDLE, n_mid, 1'b0);
              end
            end
          end
          default: begin
            // Trailing parameter: collapse each run of spaces to one
            if (sp) begin
              sp_pend = 1'b1;
            end else begin
              if (sp_pend)
                emit(imt_pkg::CH_SPACE, 1'b1, imt_pkg::KIND_TRAIL, n_mid, 1'b0);
              sp_pend = 1'b0;
              emit(b, 1'b1, imt_pkg::KIND_TRAIL, n_mid, 1'b0);
            end
          end
        endcase
      end

      if (eol) begin
        // Close whatever element is still open
        if (!too_many) begin
          if (ph == imt_pkg::PH_TAGS && in_tok)
            close_elem(imt_pkg::KIND_TAG, tag_idx);
          else if (ph == imt_pkg::PH_PREFIX)
            close_elem(imt_pkg::KIND_PREFIX, 8'd0);
          else if (ph == imt_pkg::PH_CMD)
            close_elem(imt_pkg::KIND_CMD, 8'd0);
          else if (ph == imt_pkg::PH_PARAMS && in_tok) begin
            close_elem(imt_pkg::KIND_MIDDLE, n_mid);
            count_middle();
          end else if (ph == imt_pkg::PH_TRAIL)
            close_elem(imt_pkg::KIND_TRAIL, n_mid);
        end

        // Work out the line status in priority order
        too_long = (line_len > lim_line);
        if (tag_len != 0) begin
          body = (line_len >= tag_len) ? line_len - tag_len : 16'd0;
          if (tag_len > lim_tag || body > lim_body)
            too_long = 1'b1;
        end
        if (ph == imt_pkg::PH_FIRST)
          st = imt_pkg::ST_EMPTY_CMD;
        else if (too_long)
          st = imt_pkg::ST_TOO_LONG;
        else if (ph < imt_pkg::PH_CMD)
          st = imt_pkg::ST_EMPTY_CMD;
        else if (too_many)
          st = imt_pkg::ST_TOO_LONG;
        else
          st = imt_pkg::ST_OK;
        emit(8'h00, 1'b0, imt_pkg::KIND_STATUS, 8'd0, 1'b0);
        line_tokens[line_tokens.size()-1].status = st;
        line_tokens[line_tokens.size()-1].last   = 1'b1;
        clear_line();
      end

      foreach (line_tokens[i])
        expected_tokens.insert(expected_tokens.size(), line_tokens[i]);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, seen);
        fails++;
      end
    endfunction

    function void check_token(imt_pkg::res_t got);
      imt_pkg::res_t want;
      if (expected_tokens.size() == 0) begin
        $error("result item with nothing expected: tdata byte %0d kind %0d",
               got.out_byte, got.kind);
        fails++;
        return;
      end
      want = expected_tokens.pop_front();
      cmp("out_byte",      want.out_byte,      got.out_byte);
      cmp("carries_byte",  want.carries_byte,  got.carries_byte);
      cmp("kind",          want.kind,          got.kind);
      cmp("element_index", want.element_index, got.element_index);
      cmp("ends_element",  want.ends_element,  got.ends_element);
      cmp("status",        want.status,        got.status);
      cmp("last",          want.last,          got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;   // [7:0] out_byte, [15:8] element_index,
                          // [16] ends_element, [18:17] status, rest zero
  logic [3:0]  m_tuser;   // [0] carries_byte, [3:1] kind
  logic        m_tlast;   // last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'h0000;

  irc_token_checker sb;
  logic [7:0]       line_buf[$];
  int               sent_bytes = 0;
  logic             steady = 1'b0;
  logic             hold_req = 1'b0;

  irc_message_tokenizer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: random back-pressure plus one long hold-off
  initial begin : sink
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (100) @(posedge clk);
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  // Check every accepted result item
  always @(posedge clk) begin : monitor
    imt_pkg::res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.out_byte      = m_tdata[7:0];
      got.element_index = m_tdata[15:8];
      got.ends_element  = m_tdata[16];
      got.status        = imt_pkg::status_t'(m_tdata[18:17]);
      got.carries_byte  = m_tuser[0];
      got.kind          = imt_pkg::kind_t'(m_tuser[3:1]);
      got.last          = m_tlast;
      sb.check_token(got);
    end
  end

  // Offer one byte, with an optional random gap first, and hold until taken
  task automatic send_byte(input logic [7:0] b, input logic eol);
    while (!steady && $urandom_range(0, 99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eol;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, eol);
    sent_bytes++;
  endtask

  // Append one byte to the line being built
  function automatic void add_byte(input logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  task automatic send_line();
    foreach (line_buf[i])
      send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    foreach (s[i]) add_byte(s[i]);
    send_line();
  endtask

  // Stop offering and hold until every predicted item has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no extra edge
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_limit(idx, val);
  endtask

  task automatic set_limits(input logic [15:0] tag_lim, input logic [15:0] line_lim,
                            input logic [15:0] body_lim, input logic [7:0] mid_lim);
    cfg_write(imt_pkg::REG_MAX_TAG, tag_lim);
    cfg_write(imt_pkg::REG_MAX_LINE, line_lim);
    cfg_write(imt_pkg::REG_MAX_BODY, body_lim);
    cfg_write(imt_pkg::REG_MAX_MIDDLE, {8'h00, mid_lim});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Any byte that does not split a token or a tag
  function automatic logic [7:0] rand_text();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == imt_pkg::CH_SPACE || b == imt_pkg::CH_SEMI);
    return b;
  endfunction

  function automatic void add_spaces(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) add_byte(imt_pkg::CH_SPACE);
  endfunction

  // Well-formed line with random content: tags, prefix, command, middles, trailing
  function automatic void build_line();
    int         nt, nm;
    logic [7:0] b;
    line_buf.delete();
    if ($urandom_range(0, 3) == 0) add_spaces(1, 2);
    if ($urandom_range(0, 2) == 0) begin
      add_byte(imt_pkg::CH_AT);
      nt = $urandom_range(0, 3);
      for (int t = 0; t < nt; t++) begin
        if (t > 0) add_byte(imt_pkg::CH_SEMI);
        repeat ($urandom_range(0, 4)) add_byte(rand_text());
      end
      if ($urandom_range(0, 3) == 0) add_byte(imt_pkg::CH_SEMI);
      add_spaces(1, 3);
    end
    if ($urandom_range(0, 2) == 0) begin
      add_byte(imt_pkg::CH_COLON);
      repeat ($urandom_range(0, 5)) add_byte(rand_text());
      add_spaces(1, 3);
    end
    if ($urandom_range(0, 9) != 0)
      repeat ($urandom_range(1, 5)) add_byte(rand_text());
    nm = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 4);
    repeat (nm) begin
      add_spaces(1, 3);
      do b = rand_text(); while (b == imt_pkg::CH_COLON);
      add_byte(b);
      repeat ($urandom_range(0, 3)) add_byte(rand_text());
    end
    if ($urandom_range(0, 1) == 1) begin
      add_spaces(1, 3);
      add_byte(imt_pkg::CH_COLON);
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 4)) add_byte(rand_text());
        add_spaces(1, 3);
      end
      repeat ($urandom_range(0, 3)) add_byte(rand_text());
    end
    if (line_buf.size() == 0) add_byte(rand_text());
  endfunction

  // Short line heavy in separators and markers
  function automatic void build_noise();
    line_buf.delete();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 4))
        0:       add_byte(imt_pkg::CH_SPACE);
        1:       add_byte(imt_pkg::CH_COLON);
        2:       add_byte(imt_pkg::CH_AT);
        3:       add_byte(imt_pkg::CH_SEMI);
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  // Send random lines until about the given number of bytes has gone in
  task automatic run_random(input int budget, input bit with_hold);
    int start;
    start = sent_bytes;
    while (sent_bytes - start < budget) begin
      if ($urandom_range(0, 4) == 0)
        build_noise();
      else
        build_line();
      send_line();
      if (with_hold && !hold_req) hold_req <= 1'b1;
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines at the reset limits
    line_buf.delete();
    add_byte(8'h00);
    add_byte(8'hFF);
    send_line();
    send_text("@;;a;b X");   // empty tags, then a tag closed by a space
    send_text("@x; Y");      // trailing empty segment is no tag
    send_text(": C m :");    // empty prefix and empty trailing
    send_text("A :b  c ");   // collapsed spaces in trailing
    send_text("C m");        // middle closed on its own last byte
    send_text("@");          // tag marker alone
    send_text(" ");          // no token at all
    send_text(":p");         // prefix without command

    run_random(60, 1'b0);

    // Lowest limits; a write to an unmapped index must change nothing
    wait_drained();
    cfg_write(REG_SPARE, 16'hFFFF);
    set_limits(16'd1, 16'd1, 16'd1, 8'd1);
    run_random(70, 1'b0);

    // Highest limits, no gaps on either side
    wait_drained();
    steady <= 1'b1;
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_random(75, 1'b0);

    // Tight random limits, with the long output stall
    wait_drained();
    steady <= 1'b0;
    set_limits(16'($urandom_range(2, 24)), 16'($urandom_range(10, 80)),
               16'($urandom_range(4, 60)), 8'($urandom_range(1, 5)));
    run_random(75, 1'b1);

    // Back to the reset values
    wait_drained();
    set_limits(imt_pkg::DEF_MAX_TAG, imt_pkg::DEF_MAX_LINE, imt_pkg::DEF_MAX_BODY,
               imt_pkg::DEF_MAX_MIDDLE);
    run_random(90, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.expected_tokens.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
